// ----- rtl/core/refcounted_cache_directory_assert.svh -----
// Assertion macros shared by the directory RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef REFCOUNTED_CACHE_DIRECTORY_ASSERT_SVH
`define REFCOUNTED_CACHE_DIRECTORY_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define RCD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define RCD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ----- rtl/core/rcd_pkg.sv -----
// Shared types and codes for the reference-counted cache directory.
// No dependencies; imported by the controller, datapath and top level.
`default_nettype none
package rcd_pkg;

   localparam logic OP_ACQUIRE = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

   localparam logic [2:0] ST_HIT    = 3'd0;
   localparam logic [2:0] ST_MISS   = 3'd1;
   localparam logic [2:0] ST_LOCKED = 3'd2;
   localparam logic [2:0] ST_NOFREE = 3'd3;
   localparam logic [2:0] ST_HELD   = 3'd4;
   localparam logic [2:0] ST_FREED  = 3'd5;
   localparam logic [2:0] ST_ERROR  = 3'd6;

   typedef enum logic [4:0] {
      CMD_NONE,
      CMD_LOAD,
      CMD_MOD,
      CMD_BUCKET,
      CMD_PROBE,
      CMD_HIT_CHECK,
      CMD_ALLOC,
      CMD_FU_READ,
      CMD_FU_WRITE,
      CMD_HU_READ,
      CMD_HU_WRITE,
      CMD_HI_READ1,
      CMD_HI_READ2,
      CMD_HI_LINK1,
      CMD_HI_LINK2,
      CMD_RELEASE,
      CMD_FI_READ1,
      CMD_FI_READ2,
      CMD_FI_LINK1,
      CMD_FI_LINK2
   } cmd_type;

   typedef struct packed {
      logic mod_last;
      logic bucket_used;
      logic probe_hit;
      logic probe_end;
      logic hit_go;
      logic count_zero;
      logic free_empty;
      logic entry_valid;
      logic rel_free;
   } dp_status_type;

endpackage
`default_nettype wire

// ----- rtl/core/rcd_ctrl.sv -----
// Sequencing state machine for the directory: issues one datapath command a cycle.
// Depends on rcd_pkg and the assertion macro header.
`default_nettype none
`include "refcounted_cache_directory_assert.svh"
module rcd_ctrl
   import rcd_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic          req_operation,
   input  wire dp_status_type dp_status,
   output cmd_type            cmd,
   output logic               busy,
   output logic               rsp_strobe
);

   typedef enum logic [4:0] {
      S_IDLE, S_MOD, S_BUCKET, S_PROBE, S_HIT, S_ALLOC,
      S_FU_READ, S_FU_WRITE, S_HU_READ, S_HU_WRITE,
      S_HI_READ1, S_HI_READ2, S_HI_LINK1, S_HI_LINK2,
      S_REL, S_FI_READ1, S_FI_READ2, S_FI_LINK1, S_FI_LINK2
   } state_type;

   state_type state_ff, state_in;
   logic      miss_ff, miss_in;
   logic      busy_ff, strobe_ff;
   logic      accept, finish;

   assign accept = start && !busy_ff;

   always_comb begin
      state_in = state_ff;
      miss_in  = miss_ff;
      cmd      = CMD_NONE;
      finish   = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd      = CMD_LOAD;
               state_in = (req_operation == OP_RELEASE) ? S_REL : S_MOD;
            end
         end
         S_MOD: begin
            cmd = CMD_MOD;
            if (dp_status.mod_last) state_in = S_BUCKET;
         end
         S_BUCKET: begin
            cmd      = CMD_BUCKET;
            state_in = dp_status.bucket_used ? S_PROBE : S_ALLOC;
         end
         S_PROBE: begin
            cmd = CMD_PROBE;
            if (dp_status.probe_hit) state_in = S_HIT;
            else if (dp_status.probe_end) state_in = S_ALLOC;
         end
         S_HIT: begin
            cmd     = CMD_HIT_CHECK;
            miss_in = 1'b0;
            if (dp_status.hit_go && dp_status.count_zero) state_in = S_FU_READ;
            else finish = 1'b1;
         end
         S_ALLOC: begin
            cmd     = CMD_ALLOC;
            miss_in = 1'b1;
            if (dp_status.free_empty) finish = 1'b1;
            else state_in = S_FU_READ;
         end
         S_FU_READ: begin
            cmd      = CMD_FU_READ;
            state_in = S_FU_WRITE;
         end
         S_FU_WRITE: begin
            cmd = CMD_FU_WRITE;
            if (!miss_ff) finish = 1'b1;
            else state_in = dp_status.entry_valid ? S_HU_READ : S_HI_READ1;
         end
         S_HU_READ: begin
            cmd      = CMD_HU_READ;
            state_in = S_HU_WRITE;
         end
         S_HU_WRITE: begin
            cmd      = CMD_HU_WRITE;
            state_in = S_HI_READ1;
         end
         S_HI_READ1: begin
            cmd = CMD_HI_READ1;
            if (dp_status.bucket_used) state_in = S_HI_READ2;
            else finish = 1'b1;
         end
         S_HI_READ2: begin
            cmd      = CMD_HI_READ2;
            state_in = S_HI_LINK1;
         end
         S_HI_LINK1: begin
            cmd      = CMD_HI_LINK1;
            state_in = S_HI_LINK2;
         end
         S_HI_LINK2: begin
            cmd    = CMD_HI_LINK2;
            finish = 1'b1;
         end
         S_REL: begin
            cmd = CMD_RELEASE;
            if (dp_status.rel_free) state_in = S_FI_READ1;
            else finish = 1'b1;
         end
         S_FI_READ1: begin
            cmd = CMD_FI_READ1;
            if (dp_status.free_empty) finish = 1'b1;
            else state_in = S_FI_READ2;
         end
         S_FI_READ2: begin
            cmd      = CMD_FI_READ2;
            state_in = S_FI_LINK1;
         end
         S_FI_LINK1: begin
            cmd      = CMD_FI_LINK1;
            state_in = S_FI_LINK2;
         end
         S_FI_LINK2: begin
            cmd    = CMD_FI_LINK2;
            finish = 1'b1;
         end
         default: state_in = S_IDLE;
      endcase
      if (finish) state_in = S_IDLE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         miss_ff   <= 1'b0;
         busy_ff   <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         miss_ff   <= miss_in;
         strobe_ff <= finish;
         if (accept) busy_ff <= 1'b1;
         else if (finish) busy_ff <= 1'b0;
      end
   end

   assign busy       = busy_ff;
   assign rsp_strobe = strobe_ff;

   `RCD_ASSERT_NEXT(a_accept_busy, clock, reset, accept, busy_ff)
   `RCD_ASSERT_NEXT(a_strobe_single, clock, reset, strobe_ff, !strobe_ff)
   `RCD_ASSERT_NOW(a_strobe_idle, clock, reset, strobe_ff, !busy_ff && state_ff == S_IDLE)
   `RCD_ASSERT_NOW(a_idle_free, clock, reset, state_ff == S_IDLE, !busy_ff)

endmodule
`default_nettype wire

// ----- rtl/core/rcd_datapath.sv -----
// Directory tables, free list, hash chains and scratch registers.
// Depends on rcd_pkg; executes one command from rcd_ctrl per cycle.
`default_nettype none
module rcd_datapath
   import rcd_pkg::*;
#(
   parameter int ENTRIES = 32,
   parameter int BUCKETS = 8
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire cmd_type       cmd,
   input  wire logic [7:0]    req_device,
   input  wire logic [31:0]   req_inode_number,
   input  wire logic [4:0]    req_slot,
   output dp_status_type      dp_status,
   output logic [2:0]         rsp_status,
   output logic [4:0]         rsp_result_slot,
   output logic [15:0]        rsp_reference_count
);

   localparam int IW  = $clog2(ENTRIES);
   localparam int BIW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int RW  = BIW + 1;

   // table storage
   logic [7:0]     edev_ff   [ENTRIES];
   logic [31:0]    eino_ff   [ENTRIES];
   logic [BIW-1:0] ebkt_ff   [ENTRIES];
   logic [ENTRIES-1:0] valid_ff, locked_ff;
   logic [15:0]    ref_ff    [ENTRIES];
   logic [IW-1:0]  fn_ff     [ENTRIES];
   logic [IW-1:0]  fp_ff     [ENTRIES];
   logic [IW-1:0]  cn_ff     [ENTRIES];
   logic [IW-1:0]  cp_ff     [ENTRIES];
   logic [IW-1:0]  bhead_ff  [BUCKETS];
   logic [BUCKETS-1:0] bused_ff;
   logic [IW-1:0]  free_head_ff;
   logic           free_empty_ff;

   // request and scratch
   logic [7:0]     dev_ff;
   logic [31:0]    ino_ff;
   logic           slot_hi_ff;
   logic [4:0]     req_slot_q;
   logic [RW-1:0]  rem_ff;
   logic [1:0]     byte_ff;
   logic [IW-1:0]  s_ff, p_ff, n_ff, walk_ff, step_ff;
   logic [BIW-1:0] hb_ff;
   logic           single_ff, at_head_ff;
   logic [2:0]     status_ff;
   logic [15:0]    cnt_ff;

   logic [BIW-1:0] b;
   logic [7:0]     ino_byte;
   logic [RW-1:0]  rem_shift, byte_rem;
   logic [RW:0]    mod_t;
   logic [RW:0]    mod_r;
   logic [15:0]    ref_s;

   assign b        = BIW'(rem_ff);
   assign ino_byte = ino_ff[{byte_ff, 3'b000} +: 8];

   // bucket remainder folded one byte per cycle from the top; both terms are
   // below BUCKETS, so one conditional subtract finishes each step
   always_comb begin
      rem_shift = '0;
      byte_rem  = '0;
      for (int i = 0; i < BUCKETS; i++) begin
         if (rem_ff == RW'(i)) rem_shift = RW'((i * 256) % BUCKETS);
      end
      for (int i = 0; i < 256; i++) begin
         if (ino_byte == 8'(i)) byte_rem = RW'(i % BUCKETS);
      end
   end

   assign mod_t = {1'b0, rem_shift} + {1'b0, byte_rem};
   assign mod_r = (mod_t >= (RW+1)'(BUCKETS)) ? mod_t - (RW+1)'(BUCKETS) : mod_t;
   assign ref_s = ref_ff[s_ff];

   always_comb begin
      dp_status.mod_last    = (byte_ff == 2'd0);
      dp_status.bucket_used = bused_ff[b];
      dp_status.probe_hit   = valid_ff[s_ff] && (edev_ff[s_ff] == dev_ff) &&
                              (eino_ff[s_ff] == ino_ff);
      dp_status.probe_end   = (cn_ff[s_ff] == walk_ff) || (step_ff == IW'(ENTRIES - 1));
      dp_status.hit_go      = !locked_ff[s_ff] && (ref_s != 16'hFFFF);
      dp_status.count_zero  = (ref_s == 16'd0);
      dp_status.free_empty  = free_empty_ff;
      dp_status.entry_valid = valid_ff[s_ff];
      dp_status.rel_free    = !slot_hi_ff && (ref_s == 16'd1);
   end

   // control state with defined reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         locked_ff     <= '0;
         bused_ff      <= '0;
         free_head_ff  <= '0;
         free_empty_ff <= 1'b0;
         for (int i = 0; i < ENTRIES; i++) begin
            ref_ff[i] <= 16'd0;
            fn_ff[i]  <= IW'((i + 1) % ENTRIES);
            fp_ff[i]  <= IW'((i + ENTRIES - 1) % ENTRIES);
         end
      end else begin
         case (cmd)
            CMD_HIT_CHECK: begin
               if (!locked_ff[s_ff] && ref_s != 16'hFFFF) begin
                  locked_ff[s_ff] <= 1'b1;
                  ref_ff[s_ff]    <= ref_s + 16'd1;
               end
            end
            CMD_ALLOC: begin
               if (!free_empty_ff) begin
                  locked_ff[free_head_ff] <= 1'b1;
                  ref_ff[free_head_ff]    <= 16'd1;
               end
            end
            CMD_FU_WRITE: begin
               if (!free_empty_ff) begin
                  if (single_ff) begin
                     free_empty_ff <= 1'b1;
                     free_head_ff  <= '0;
                  end else begin
                     fn_ff[p_ff] <= n_ff;
                     fp_ff[n_ff] <= p_ff;
                     if (s_ff == free_head_ff) free_head_ff <= n_ff;
                  end
               end
            end
            CMD_HU_WRITE: begin
               if (bused_ff[hb_ff] && single_ff) bused_ff[hb_ff] <= 1'b0;
            end
            CMD_HI_READ1: begin
               valid_ff[s_ff] <= 1'b1;
               if (!bused_ff[b]) bused_ff[b] <= 1'b1;
            end
            CMD_RELEASE: begin
               if (!slot_hi_ff && ref_s != 16'd0) begin
                  ref_ff[s_ff]    <= ref_s - 16'd1;
                  locked_ff[s_ff] <= 1'b0;
               end
            end
            CMD_FI_READ1: begin
               if (free_empty_ff) begin
                  free_head_ff  <= s_ff;
                  fn_ff[s_ff]   <= s_ff;
                  fp_ff[s_ff]   <= s_ff;
                  free_empty_ff <= 1'b0;
               end
            end
            CMD_FI_LINK1: begin
               fn_ff[s_ff] <= n_ff;
               fp_ff[s_ff] <= p_ff;
            end
            CMD_FI_LINK2: begin
               fn_ff[p_ff] <= s_ff;
               fp_ff[n_ff] <= s_ff;
               if (at_head_ff) free_head_ff <= s_ff;
            end
            default: ;
         endcase
      end
   end

   // payload tables and scratch registers
   always_ff @(posedge clock) begin
      case (cmd)
         CMD_LOAD: begin
            dev_ff     <= req_device;
            ino_ff     <= req_inode_number;
            s_ff       <= IW'(req_slot);
            slot_hi_ff <= (32'(req_slot) >= ENTRIES);
            req_slot_q <= req_slot;
            rem_ff     <= '0;
            byte_ff    <= 2'd3;
         end
         CMD_MOD: begin
            // acquires carry no slot
            slot_hi_ff <= 1'b0;
            rem_ff     <= RW'(mod_r);
            byte_ff    <= byte_ff - 2'd1;
         end
         CMD_BUCKET: begin
            s_ff    <= bhead_ff[b];
            walk_ff <= bhead_ff[b];
            step_ff <= '0;
         end
         CMD_PROBE: begin
            if (!dp_status.probe_hit) begin
               s_ff    <= cn_ff[s_ff];
               step_ff <= step_ff + IW'(1);
            end
         end
         CMD_HIT_CHECK: begin
            if (locked_ff[s_ff]) begin
               status_ff <= ST_LOCKED;
               cnt_ff    <= ref_s;
            end else if (ref_s == 16'hFFFF) begin
               status_ff <= ST_ERROR;
               cnt_ff    <= ref_s;
            end else begin
               status_ff <= ST_HIT;
               cnt_ff    <= ref_s + 16'd1;
            end
         end
         CMD_ALLOC: begin
            if (free_empty_ff) begin
               status_ff <= ST_NOFREE;
               s_ff      <= '0;
               cnt_ff    <= 16'd0;
            end else begin
               status_ff <= ST_MISS;
               s_ff      <= free_head_ff;
               cnt_ff    <= 16'd1;
            end
         end
         CMD_FU_READ: begin
            p_ff      <= fp_ff[s_ff];
            n_ff      <= fn_ff[s_ff];
            single_ff <= (fn_ff[s_ff] == s_ff);
         end
         CMD_HU_READ: begin
            p_ff      <= cp_ff[s_ff];
            n_ff      <= cn_ff[s_ff];
            single_ff <= (cn_ff[s_ff] == s_ff);
            hb_ff     <= ebkt_ff[s_ff];
         end
         CMD_HU_WRITE: begin
            if (bused_ff[hb_ff] && !single_ff) begin
               cn_ff[p_ff] <= n_ff;
               cp_ff[n_ff] <= p_ff;
               if (s_ff == bhead_ff[hb_ff]) bhead_ff[hb_ff] <= n_ff;
            end
         end
         CMD_HI_READ1: begin
            edev_ff[s_ff] <= dev_ff;
            eino_ff[s_ff] <= ino_ff;
            ebkt_ff[s_ff] <= b;
            if (!bused_ff[b]) begin
               bhead_ff[b] <= s_ff;
               cn_ff[s_ff] <= s_ff;
               cp_ff[s_ff] <= s_ff;
            end else begin
               n_ff <= bhead_ff[b];
            end
         end
         CMD_HI_READ2: p_ff <= cp_ff[n_ff];
         CMD_HI_LINK1: begin
            cn_ff[s_ff] <= n_ff;
            cp_ff[s_ff] <= p_ff;
         end
         CMD_HI_LINK2: begin
            cn_ff[p_ff] <= s_ff;
            cp_ff[n_ff] <= s_ff;
            bhead_ff[b] <= s_ff;
         end
         CMD_RELEASE: begin
            at_head_ff <= !valid_ff[s_ff];
            if (slot_hi_ff || ref_s == 16'd0) begin
               status_ff <= ST_ERROR;
               cnt_ff    <= 16'd0;
            end else begin
               status_ff <= (ref_s == 16'd1) ? ST_FREED : ST_HELD;
               cnt_ff    <= ref_s - 16'd1;
            end
         end
         CMD_FI_READ1: n_ff <= free_head_ff;
         CMD_FI_READ2: p_ff <= fp_ff[n_ff];
         default: ;
      endcase
   end

   // out-of-range releases report the slot as requested
   assign rsp_status          = status_ff;
   assign rsp_result_slot     = slot_hi_ff ? req_slot_q : 5'(s_ff);
   assign rsp_reference_count = cnt_ff;

endmodule
`default_nettype wire

// ----- rtl/core/refcounted_cache_directory.sv -----
// Top level of the reference-counted cache directory.
// Depends on rcd_pkg, rcd_ctrl and rcd_datapath.
//
// Usage: a request is taken at a rising edge with start high and busy low.
// req_operation 0 acquires by req_device and req_inode_number; 1 releases
// req_slot. Each request yields exactly one response, shown for one cycle
// with rsp_strobe high: rsp_status, rsp_result_slot, rsp_reference_count.
// The receiver cannot stall; the response is taken in its strobe cycle.
// A release decrements the slot's count, freeing the slot at zero. An
// acquire first reduces the inode number modulo BUCKETS one byte per cycle,
// reads the bucket head, walks the bucket chain one slot per cycle (at most
// ENTRIES slots), then updates free-list and chain pointers as needed; the
// strobe is registered from the last step. busy drops in the strobe cycle,
// so the next request may be taken while the previous response is shown.
// Reset clears all valid, lock and count state and puts every slot on the
// free list in slot order; no clearing pass is needed.
`default_nettype none
module refcounted_cache_directory
   import rcd_pkg::*;
#(
   parameter int ENTRIES = 32,
   parameter int BUCKETS = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic        req_operation,
   input  wire logic [7:0]  req_device,
   input  wire logic [31:0] req_inode_number,
   input  wire logic [4:0]  req_slot,
   output logic             rsp_strobe,
   output logic [2:0]       rsp_status,
   output logic [4:0]       rsp_result_slot,
   output logic [15:0]      rsp_reference_count
);

   cmd_type       cmd;
   dp_status_type dp_status;

   rcd_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .req_operation (req_operation),
      .dp_status     (dp_status),
      .cmd           (cmd),
      .busy          (busy),
      .rsp_strobe    (rsp_strobe)
   );

   rcd_datapath #(
      .ENTRIES (ENTRIES),
      .BUCKETS (BUCKETS)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .req_device          (req_device),
      .req_inode_number    (req_inode_number),
      .req_slot            (req_slot),
      .dp_status           (dp_status),
      .rsp_status          (rsp_status),
      .rsp_result_slot     (rsp_result_slot),
      .rsp_reference_count (rsp_reference_count)
   );

endmodule
`default_nettype wire
